>>> sv/xeu_pkg.sv
`timescale 1ns / 1ps

package xeu_pkg;

  // character codes used by the entity decoder
  localparam logic [7:0] CHAR_AMP    = 8'h26;  // '&'
  localparam logic [7:0] CHAR_SEMI   = 8'h3B;  // ';'
  localparam logic [7:0] CHAR_HASH   = 8'h23;  // '#'
  localparam logic [7:0] CHAR_LOW_X  = 8'h78;  // 'x'
  localparam logic [7:0] CHAR_LOW_G  = 8'h67;  // 'g'
  localparam logic [7:0] CHAR_LOW_L  = 8'h6C;  // 'l'
  localparam logic [7:0] CHAR_LOW_T  = 8'h74;  // 't'
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LOW_M  = 8'h6D;  // 'm'
  localparam logic [7:0] CHAR_LOW_P  = 8'h70;  // 'p'
  localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE   = 8'h39;  // '9'
  localparam logic [7:0] CHAR_GT     = 8'h3E;  // '>'
  localparam logic [7:0] CHAR_LT     = 8'h3C;  // '<'

  // entity name store
  localparam int unsigned NAME_CHARS = 3;
  localparam int unsigned LEN_MAX    = 4;
  localparam int unsigned LEN_W      = 3;

endpackage

>>> sv/xml_entity_unescape.sv
`timescale 1ns / 1ps
// an accepted input transaction that produces a result is registered in the output register
// throughput: one byte per cycle while in_stall is low; in_stall rises only while a held result is stalled
// bytes that open or extend an entity produce no result and only update the entity state
// reset: synchronous active-low rst_n returns to text mode and empties the output register
// the entity name, length and decimal value are cleared on reset and the digit flag is set
module xml_entity_unescape (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_error,
  output logic       out_last
);

  typedef enum logic [1:0] {
    MODE_TEXT    = 2'd0,
    MODE_ENTITY  = 2'd1,
    MODE_DISCARD = 2'd2
  } mode_t;

  mode_t                      mode_r, mode_nxt;
  logic [8*xeu_pkg::NAME_CHARS-1:0] chars_r, chars_nxt;
  logic [xeu_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [7:0]                 code_r, code_nxt;
  logic                       digits_r, digits_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_error_r, out_error_nxt;
  logic       out_last_r, out_last_nxt;

  logic       in_acc;
  logic       emit;
  logic [7:0] emit_char;
  logic       emit_err;

  // entity state after appending the current byte
  logic [8*xeu_pkg::NAME_CHARS-1:0] app_chars;
  logic [xeu_pkg::LEN_W-1:0]  app_len;
  logic [7:0]                 app_code;
  logic                       app_digits;
  logic                       is_digit;
  logic [7:0]                 c0, c1, c2;
  logic                       res_ok;
  logic [7:0]                 res_char;

  // accept whenever the output register is free or draining
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // append one name character
  always_comb begin
    is_digit   = in_byte inside {[xeu_pkg::CHAR_ZERO:xeu_pkg::CHAR_NINE]};
    app_chars  = chars_r;
    app_len    = len_r;
    app_code   = code_r;
    app_digits = digits_r;
    if (len_r != '0 && digits_r) begin
      if (is_digit) begin
        app_code = (code_r << 3) + (code_r << 1) + (in_byte - xeu_pkg::CHAR_ZERO);
      end else begin
        app_digits = 1'b0;
      end
    end
    case (len_r)
      3'd0:    app_chars[7:0]   = in_byte;
      3'd1:    app_chars[15:8]  = in_byte;
      3'd2:    app_chars[23:16] = in_byte;
      default: app_chars        = chars_r;
    endcase
    if (len_r < xeu_pkg::LEN_W'(xeu_pkg::LEN_MAX)) begin
      app_len = len_r + 1'b1;
    end
  end

  // resolve the name: after the append unless the byte is the terminating semicolon
  always_comb begin
    logic [8*xeu_pkg::NAME_CHARS-1:0] nm;
    logic [xeu_pkg::LEN_W-1:0]        ln;
    logic [7:0]                       cv;
    nm = (in_byte == xeu_pkg::CHAR_SEMI) ? chars_r : app_chars;
    ln = (in_byte == xeu_pkg::CHAR_SEMI) ? len_r   : app_len;
    cv = (in_byte == xeu_pkg::CHAR_SEMI) ? code_r  : app_code;
    c0 = nm[7:0];
    c1 = nm[15:8];
    c2 = nm[23:16];
    res_ok   = 1'b0;
    res_char = 8'd0;
    if (ln == 3'd2 && c0 == xeu_pkg::CHAR_LOW_G && c1 == xeu_pkg::CHAR_LOW_T) begin
      res_ok   = 1'b1;
      res_char = xeu_pkg::CHAR_GT;
    end else if (ln == 3'd2 && c0 == xeu_pkg::CHAR_LOW_L && c1 == xeu_pkg::CHAR_LOW_T) begin
      res_ok   = 1'b1;
      res_char = xeu_pkg::CHAR_LT;
    end else if (ln == 3'd3 && c0 == xeu_pkg::CHAR_LOW_A && c1 == xeu_pkg::CHAR_LOW_M
                 && c2 == xeu_pkg::CHAR_LOW_P) begin
      res_ok   = 1'b1;
      res_char = xeu_pkg::CHAR_AMP;
    end else if (ln != '0 && c0 == xeu_pkg::CHAR_HASH
                 && (ln == 3'd1 || c1 != xeu_pkg::CHAR_LOW_X)) begin
      res_ok   = 1'b1;
      res_char = cv;
    end
  end

  // mode transitions and result selection
  always_comb begin
    mode_nxt   = mode_r;
    chars_nxt  = chars_r;
    len_nxt    = len_r;
    code_nxt   = code_r;
    digits_nxt = digits_r;
    emit       = 1'b0;
    emit_char  = 8'd0;
    emit_err   = 1'b0;
    case (mode_r)
      MODE_ENTITY: begin
        if (in_byte != xeu_pkg::CHAR_SEMI) begin
          chars_nxt  = app_chars;
          len_nxt    = app_len;
          code_nxt   = app_code;
          digits_nxt = app_digits;
        end
        if (in_byte == xeu_pkg::CHAR_SEMI || in_last) begin
          emit = 1'b1;
          if (res_ok) begin
            mode_nxt  = MODE_TEXT;
            emit_char = res_char;
          end else begin
            mode_nxt = in_last ? MODE_TEXT : MODE_DISCARD;
            emit_err = 1'b1;
          end
        end
      end
      MODE_DISCARD: begin
        if (in_last) begin
          mode_nxt = MODE_TEXT;
          emit     = 1'b1;
          emit_err = 1'b1;
        end
      end
      default: begin
        mode_nxt = MODE_TEXT;
        if (in_byte == xeu_pkg::CHAR_AMP) begin
          chars_nxt  = '0;
          len_nxt    = '0;
          code_nxt   = '0;
          digits_nxt = 1'b1;
          if (in_last) begin
            emit     = 1'b1;
            emit_err = 1'b1;
          end else begin
            mode_nxt = MODE_ENTITY;
          end
        end else begin
          emit      = 1'b1;
          emit_char = in_byte;
        end
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_error_nxt = out_error_r;
    out_last_nxt  = out_last_r;
    if (in_acc && emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = emit_char;
      out_error_nxt = emit_err;
      out_last_nxt  = in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_TEXT;
      chars_r     <= '0;
      len_r       <= '0;
      code_r      <= '0;
      digits_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_r   <= mode_nxt;
        chars_r  <= chars_nxt;
        len_r    <= len_nxt;
        code_r   <= code_nxt;
        digits_r <= digits_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_char_r  <= out_char_nxt;
    out_error_r <= out_error_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_error = out_error_r;
  assign out_last  = out_last_r;

endmodule

>>> sv/xeu_checker.sv
`timescale 1ns / 1ps

module xeu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       out_error,
  input logic       out_last
);

  // a stalled result stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_char) && $stable(out_error) && $stable(out_last))
    else $error("result changed while stalled");

  // an error result carries a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_char == 8'd0)
    else $error("error result with non-zero byte");

  // input back-pressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // a new result only follows an accepted input transaction
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without input transaction");

endmodule

bind xml_entity_unescape xeu_checker u_xeu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_char  (out_char),
  .out_error (out_error),
  .out_last  (out_last)
);
